// ===== design/pbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Pileup base frequency package
// Shared character codes and the reference code that marks no usable base, used
// by the front end of the parser.
// ----------------------------------------------------------------------------
`default_nettype none
package pbf_pkg;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [2:0] REF_NONE = 3'd4;
endpackage
`default_nettype wire

// ===== design/pbf_if.sv =====
// ----------------------------------------------------------------------------
// Pileup channel interfaces
// Valid/ready channels for text bytes and for per-line results.
// ----------------------------------------------------------------------------
`default_nettype none
interface pbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface pbf_out_if #(parameter int COUNT_BITS = 20, parameter int FRAC_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [FRAC_BITS:0]    freq_a;
  logic [FRAC_BITS:0]    freq_c;
  logic [FRAC_BITS:0]    freq_t;
  logic [FRAC_BITS:0]    freq_g;
  logic [COUNT_BITS-1:0] count_a;
  logic [COUNT_BITS-1:0] count_c;
  logic [COUNT_BITS-1:0] count_t;
  logic [COUNT_BITS-1:0] count_g;
  logic [COUNT_BITS-1:0] adjusted_depth;
  logic                  zero_depth;
  modport source (output valid, freq_a, freq_c, freq_t, freq_g, count_a, count_c,
                  count_t, count_g, adjusted_depth, zero_depth, input ready);
  modport sink (input valid, freq_a, freq_c, freq_t, freq_g, count_a, count_c,
                count_t, count_g, adjusted_depth, zero_depth, output ready);
endinterface
`default_nettype wire

// ===== design/pbf_front.sv =====
// ----------------------------------------------------------------------------
// Pileup front end
// Tracks fields of each line, counts bases and emits a line summary on newline.
// ----------------------------------------------------------------------------
`default_nettype none
module pbf_front #(
  parameter int COUNT_BITS = 20,
  parameter int INDEL_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    byte_valid,
  input  wire logic [7:0]              byte_in,
  output logic                         line_valid,
  output logic [4*COUNT_BITS-1:0]      line_counts,
  output logic [COUNT_BITS-1:0]        line_depth
);
  import pbf_pkg::*;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;
  localparam logic [INDEL_BITS-1:0] IMAX = '1;

  logic [2:0]            field_r;
  logic [2:0]            ref_r;
  logic [COUNT_BITS-1:0] depth_r;
  logic [COUNT_BITS-1:0] cnt_r [4];
  logic                  skip_r, indel_r, fstart_r, ddone_r;
  logic [INDEL_BITS-1:0] ilen_r, skipn_r;
  logic [3:0]            digit;
  logic                  is_digit;
  logic [COUNT_BITS+4:0] dnext;
  logic [INDEL_BITS+4:0] inext;
  logic [2:0]            bump;
  logic                  dec;

  assign is_digit = byte_in >= CH_ZERO && byte_in <= CH_NINE;
  assign digit = 4'(byte_in - CH_ZERO);
  assign dnext = (COUNT_BITS+5)'(depth_r) * (COUNT_BITS+5)'(10) + (COUNT_BITS+5)'(digit);
  assign inext = (INDEL_BITS+5)'(ilen_r) * (INDEL_BITS+5)'(10) + (INDEL_BITS+5)'(digit);

  always_comb begin
    bump = REF_NONE;
    dec  = 1'b0;
    case (byte_in)
      8'h41, 8'h61: bump = 3'd0;
      8'h43, 8'h63: bump = 3'd1;
      8'h54, 8'h74: bump = 3'd2;
      8'h47, 8'h67: bump = 3'd3;
      CH_DOT, CH_COMMA: bump = ref_r;
      CH_CARET, CH_DOLL, CH_PLUS, CH_MINUS: bump = REF_NONE;
      default: dec = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    line_valid <= rst_n && byte_valid && byte_in == CH_NL;
    if (!rst_n || (byte_valid && byte_in == CH_NL)) begin
      if (rst_n) begin
        line_counts <= {cnt_r[3], cnt_r[2], cnt_r[1], cnt_r[0]};
        line_depth  <= depth_r;
      end
      field_r <= '0; ref_r <= REF_NONE; depth_r <= '0;
      for (int k = 0; k < 4; k++) cnt_r[k] <= '0;
      skip_r <= 1'b0; indel_r <= 1'b0; ilen_r <= '0; skipn_r <= '0;
      fstart_r <= 1'b1; ddone_r <= 1'b0;
    end else if (byte_valid && byte_in == CH_TAB) begin
      if (field_r != 3'd7) field_r <= field_r + 3'd1;
      fstart_r <= 1'b1; skip_r <= 1'b0; indel_r <= 1'b0;
      ilen_r <= '0; skipn_r <= '0;
    end else if (byte_valid) begin
      fstart_r <= 1'b0;
      if (field_r == 3'd2) begin
        if (fstart_r) begin
          case (byte_in)
            8'h41: ref_r <= 3'd0;
            8'h43: ref_r <= 3'd1;
            8'h54: ref_r <= 3'd2;
            8'h47: ref_r <= 3'd3;
            default: ref_r <= REF_NONE;
          endcase
        end
      end else if (field_r == 3'd3) begin
        if (!ddone_r) begin
          if (is_digit) depth_r <= (dnext > (COUNT_BITS+5)'(CMAX)) ? CMAX
                                   : dnext[COUNT_BITS-1:0];
          else ddone_r <= 1'b1;
        end
      end else if (field_r == 3'd4) begin
        if (skip_r) skip_r <= 1'b0;
        else if (skipn_r != '0) skipn_r <= skipn_r - 1'b1;
        else if (indel_r && is_digit)
          ilen_r <= (inext > (INDEL_BITS+5)'(IMAX)) ? IMAX : inext[INDEL_BITS-1:0];
        else if (indel_r && ilen_r != '0) begin
          indel_r <= 1'b0;
          skipn_r <= ilen_r - 1'b1;
          ilen_r  <= '0;
        end else begin
          indel_r <= byte_in == CH_PLUS || byte_in == CH_MINUS;
          if (byte_in == CH_CARET) skip_r <= 1'b1;
          if (bump != REF_NONE && cnt_r[bump[1:0]] != CMAX)
            cnt_r[bump[1:0]] <= cnt_r[bump[1:0]] + 1'b1;
          if (dec && depth_r != '0) depth_r <= depth_r - 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/pbf_fifo.sv =====
// ----------------------------------------------------------------------------
// Line summary queue
// Small first-in first-out store between the front end and the divider. Read
// data is registered and holds the entry taken at the previous read.
// ----------------------------------------------------------------------------
`default_nettype none
module pbf_fifo #(
  parameter int WIDTH = 100,
  parameter int DEPTH_LOG = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  logic [WIDTH-1:0]     mem [2**DEPTH_LOG];
  logic [DEPTH_LOG:0]   wp_r, rp_r;

  assign empty   = wp_r == rp_r;
  assign full    = (wp_r[DEPTH_LOG] != rp_r[DEPTH_LOG]) &&
                   (wp_r[DEPTH_LOG-1:0] == rp_r[DEPTH_LOG-1:0]);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r[DEPTH_LOG-1:0]] <= wr_data;
    if (rd_en) rd_data <= mem[rp_r[DEPTH_LOG-1:0]];
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== design/pbf_back.sv =====
// ----------------------------------------------------------------------------
// Pileup back end
// Restoring divider producing four saturated frequencies, one quotient bit
// per cycle, then holding the result until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module pbf_back #(
  parameter int COUNT_BITS = 20,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    job_valid,
  input  wire logic [4*COUNT_BITS-1:0] job_counts,
  input  wire logic [COUNT_BITS-1:0]   job_depth,
  output logic                         job_take,
  pbf_out_if.source                    out_ch
);
  localparam int QB = COUNT_BITS + FRAC_BITS;
  localparam int SB = $clog2(QB + 1);
  localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_OUT = 2'd2, S_LOAD = 2'd3;
  localparam logic [QB-1:0] ONE = QB'(1) << FRAC_BITS;

  logic [1:0]            st_r;
  logic [1:0]            lane_r;
  logic [SB-1:0]         bit_r;
  logic [QB-1:0]         num_r, quo_r;
  logic [COUNT_BITS:0]   rem_r;
  logic [COUNT_BITS-1:0] den_r;
  logic [COUNT_BITS-1:0] cnt_r [4];
  logic [FRAC_BITS:0]    frq_r [4];
  logic [COUNT_BITS:0]   trial;
  logic                  ge;
  logic [QB-1:0]         qn;

  assign trial = {rem_r[COUNT_BITS-1:0], num_r[QB-1]};
  assign ge = trial >= {1'b0, den_r};
  assign qn = {quo_r[QB-2:0], ge};
  assign job_take = st_r == S_IDLE && job_valid;

  assign out_ch.valid = st_r == S_OUT;
  assign out_ch.freq_a = frq_r[0];
  assign out_ch.freq_c = frq_r[1];
  assign out_ch.freq_t = frq_r[2];
  assign out_ch.freq_g = frq_r[3];
  assign out_ch.count_a = cnt_r[0];
  assign out_ch.count_c = cnt_r[1];
  assign out_ch.count_t = cnt_r[2];
  assign out_ch.count_g = cnt_r[3];
  assign out_ch.adjusted_depth = den_r;
  assign out_ch.zero_depth = den_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (job_valid) st_r <= S_LOAD;
        end
        S_LOAD: begin
          for (int k = 0; k < 4; k++)
            cnt_r[k] <= job_counts[k*COUNT_BITS +: COUNT_BITS];
          den_r  <= job_depth;
          lane_r <= 2'd0;
          bit_r  <= SB'(QB);
          num_r  <= {job_counts[COUNT_BITS-1:0], {FRAC_BITS{1'b0}}};
          rem_r  <= '0;
          quo_r  <= '0;
          st_r   <= S_DIV;
        end
        S_DIV: begin
          if (bit_r != '0) begin
            rem_r <= ge ? trial - {1'b0, den_r} : trial;
            num_r <= {num_r[QB-2:0], 1'b0};
            quo_r <= qn;
            bit_r <= bit_r - 1'b1;
          end else begin
            frq_r[lane_r] <= (den_r == '0) ? '0 :
                             (quo_r > ONE) ? ONE[FRAC_BITS:0] : quo_r[FRAC_BITS:0];
            if (lane_r == 2'd3) begin
              st_r <= S_OUT;
            end else begin
              lane_r <= lane_r + 2'd1;
              bit_r  <= SB'(QB);
              num_r  <= {cnt_r[lane_r + 2'd1], {FRAC_BITS{1'b0}}};
              rem_r  <= '0;
              quo_r  <= '0;
            end
          end
        end
        S_OUT: if (out_ch.ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/pileup_base_frequency_parser.sv =====
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, held off for the cycle after each newline and while
// the four-entry queue is full.
// Reset: synchronous active-low rst_n clears line state, queue pointers and the divider.
// ----------------------------------------------------------------------------
`default_nettype none
module pileup_base_frequency_parser #(
  parameter int COUNT_BITS = 20,
  parameter int INDEL_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input wire logic  clk,
  input wire logic  rst_n,
  pbf_in_if.sink    in_ch,
  pbf_out_if.source out_ch
);
  import pbf_pkg::*;
  localparam int W = 5 * COUNT_BITS;

  logic                    lv, full, empty, take;
  logic [4*COUNT_BITS-1:0] lc;
  logic [COUNT_BITS-1:0]   ld;
  logic [W-1:0]            rd;
  logic                    acc;

  assign in_ch.ready = !full && !lv;
  assign acc = in_ch.valid && in_ch.ready;

  pbf_front #(.COUNT_BITS(COUNT_BITS), .INDEL_BITS(INDEL_BITS)) u_front (
    .clk, .rst_n, .byte_valid(acc), .byte_in(in_ch.char_byte),
    .line_valid(lv), .line_counts(lc), .line_depth(ld));

  // The front writes a line in the cycle after its newline, so input waits in that cycle.
  pbf_fifo #(.WIDTH(W), .DEPTH_LOG(2)) u_fifo (
    .clk, .rst_n, .wr_en(lv), .wr_data({ld, lc}), .full(full),
    .rd_en(take), .rd_data(rd), .empty(empty));

  pbf_back #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .job_valid(!empty), .job_counts(rd[4*COUNT_BITS-1:0]),
    .job_depth(rd[W-1:4*COUNT_BITS]), .job_take(take), .out_ch(out_ch));

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !lv) else $error("line queue overflow");
  a_freq_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.freq_a <= (FRAC_BITS+1)'(1) << FRAC_BITS)
    else $error("frequency above one");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.zero_depth |-> out_ch.freq_g == '0)
    else $error("nonzero frequency at zero depth");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/pbf_tb_if.sv =====
// ----------------------------------------------------------------------------
// Pileup testbench channel note
// The block's channel interfaces are declared with the design; this file
// holds the record type that the testbench uses for one line result.
// ----------------------------------------------------------------------------
package pbf_tb_pkg;
  typedef struct packed {
    logic [16:0] freq_a;
    logic [16:0] freq_c;
    logic [16:0] freq_t;
    logic [16:0] freq_g;
    logic [19:0] count_a;
    logic [19:0] count_c;
    logic [19:0] count_t;
    logic [19:0] count_g;
    logic [19:0] adjusted_depth;
    logic        zero_depth;
  } line_result_t;
endpackage

// ===== tb/sv/pileup_base_frequency_parser_tb.sv =====
// ----------------------------------------------------------------------------
// Pileup base frequency parser testbench
// Streams directed and random pileup lines into the parser, predicts each
// line's counts, depth and frequencies, and checks every result transaction
// in order, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module pileup_base_frequency_parser_tb;
  import pbf_pkg::*;
  import pbf_tb_pkg::*;

  localparam int CB = 20;
  localparam int IB = 16;
  localparam int FB = 16;
  localparam logic [CB-1:0] CMAX = '1;
  localparam logic [IB-1:0] IMAX = '1;

  class line_scoreboard;
    logic [2:0] field_no;
    logic [2:0] ref_idx;
    logic [CB-1:0] depth;
    logic [CB-1:0] counts [4];
    bit skip_one, indel_mode, at_field_start, depth_ended;
    logic [IB-1:0] indel_len, skip_left;
    line_result_t pending [$];
    int errors, lines_seen, bytes_seen;

    function void clear_line();
      field_no = 0; ref_idx = REF_NONE; depth = 0;
      for (int k = 0; k < 4; k++) counts[k] = 0;
      skip_one = 0; indel_mode = 0; indel_len = 0; skip_left = 0;
      at_field_start = 1; depth_ended = 0;
    endfunction

    function void bump(int k);
      if (k < 4 && counts[k] != CMAX) counts[k]++;
    endfunction

    function logic [FB:0] ratio(logic [CB-1:0] c, logic [CB-1:0] d);
      logic [63:0] q;
      if (d == 0) return 0;
      q = ({44'd0, c} << FB) / d;
      return (q > (64'd1 << FB)) ? ((FB+1)'(1) << FB) : q[FB:0];
    endfunction

    function void read_symbol(logic [7:0] c);
      case (c)
        "A", "a": bump(0);
        "C", "c": bump(1);
        "T", "t": bump(2);
        "G", "g": bump(3);
        CH_CARET: skip_one = 1;
        CH_DOT, CH_COMMA: bump(ref_idx);
        CH_DOLL: ;
        CH_PLUS, CH_MINUS: begin
          indel_mode = 1; indel_len = 0;
        end
        default: if (depth > 0) depth--;
      endcase
    endfunction

    function void read_base_byte(logic [7:0] c);
      logic [63:0] v;
      if (skip_one) begin
        skip_one = 0; return;
      end
      if (skip_left > 0) begin
        skip_left--; return;
      end
      if (indel_mode) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          v = indel_len * 64'd10 + (c - CH_ZERO);
          indel_len = (v > IMAX) ? IMAX : v[IB-1:0];
          return;
        end
        indel_mode = 0;
        if (indel_len > 0) begin
          skip_left = indel_len - 1'b1; indel_len = 0; return;
        end
      end
      read_symbol(c);
    endfunction

    function void note_byte(logic [7:0] c);
      line_result_t r;
      logic [63:0] v;
      bit first;
      first = at_field_start;
      bytes_seen++;
      if (c == CH_NL) begin
        r.freq_a = ratio(counts[0], depth); r.freq_c = ratio(counts[1], depth);
        r.freq_t = ratio(counts[2], depth); r.freq_g = ratio(counts[3], depth);
        r.count_a = counts[0]; r.count_c = counts[1];
        r.count_t = counts[2]; r.count_g = counts[3];
        r.adjusted_depth = depth; r.zero_depth = (depth == 0);
        pending = {pending, r};
        clear_line();
        return;
      end
      if (c == CH_TAB) begin
        if (field_no < 7) field_no++;
        at_field_start = 1; skip_one = 0; indel_mode = 0; indel_len = 0; skip_left = 0;
        return;
      end
      at_field_start = 0;
      if (field_no == 2) begin
        if (first) begin
          case (c)
            "A": ref_idx = 0;
            "C": ref_idx = 1;
            "T": ref_idx = 2;
            "G": ref_idx = 3;
            default: ref_idx = REF_NONE;
          endcase
        end
      end else if (field_no == 3) begin
        if (!depth_ended) begin
          if (c >= CH_ZERO && c <= CH_NINE) begin
            v = depth * 64'd10 + (c - CH_ZERO);
            depth = (v > CMAX) ? CMAX : v[CB-1:0];
          end else depth_ended = 1;
        end
      end else if (field_no == 4) read_base_byte(c);
    endfunction

    function void check_result(line_result_t got);
      line_result_t exp;
      lines_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        errors++;
        $display("%0t: result mismatch expected %h actual %h", $time, exp, got);
        $display("  freq a/c/t/g exp %0d %0d %0d %0d act %0d %0d %0d %0d",
                 exp.freq_a, exp.freq_c, exp.freq_t, exp.freq_g,
                 got.freq_a, got.freq_c, got.freq_t, got.freq_g);
        $display("  count a/c/t/g exp %0d %0d %0d %0d act %0d %0d %0d %0d",
                 exp.count_a, exp.count_c, exp.count_t, exp.count_g,
                 got.count_a, got.count_c, got.count_t, got.count_g);
        $display("  depth exp %0d/%0d act %0d/%0d", exp.adjusted_depth, exp.zero_depth,
                 got.adjusted_depth, got.zero_depth);
      end
    endfunction
  endclass

  logic clk, rst_n;
  pbf_in_if in_ch ();
  pbf_out_if #(.COUNT_BITS(CB), .FRAC_BITS(FB)) out_ch ();

  pileup_base_frequency_parser #(.COUNT_BITS(CB), .INDEL_BITS(IB), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  line_scoreboard sb;
  byte unsigned text_q [$];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_byte(byte unsigned c);
    int g;
    g = gap_len();
    repeat (g) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_byte <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(c);
    @(negedge clk);
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) text_q = {text_q, byte'(s[i])};
  endtask

  function automatic string rand_reads(int n);
    string s;
    string sym;
    sym = "ACGTacgt.,.,^$+-N*x";
    s = "";
    for (int i = 0; i < n; i++) begin
      int p;
      p = $urandom_range(0, 99);
      if (p < 70) s = {s, string'(sym[$urandom_range(0, 11)])};
      else if (p < 78) s = {s, "^", string'(byte'($urandom_range(33, 126)))};
      else if (p < 84) s = {s, "$"};
      else if (p < 93) begin
        int len;
        len = $urandom_range(0, 4);
        s = {s, ($urandom_range(0, 1) ? "+" : "-"), $sformatf("%0d", len)};
        for (int j = 0; j < len; j++) s = {s, string'(sym[$urandom_range(0, 7)])};
      end else s = {s, string'(sym[$urandom_range(15, 18)])};
    end
    return s;
  endfunction

  task automatic gen_random_line();
    int p;
    string refb;
    string bases;
    bases = "ACTG";
    p = $urandom_range(0, 99);
    if (p < 80) begin
      refb = $urandom_range(0, 5) == 0 ? "N" : string'(bases[$urandom_range(0, 3)]);
      push_str({"chr1\t", $sformatf("%0d", $urandom_range(1, 99999)), "\t", refb, "\t",
                $sformatf("%0d", $urandom_range(0, 30)), "\t",
                rand_reads($urandom_range(0, 20)), "\tIIII\n"});
    end else begin
      int n;
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) begin
        int q;
        q = $urandom_range(0, 9);
        text_q = {text_q, (q < 2 ? CH_TAB : 8'($urandom_range(0, 255)))};
      end
      text_q = {text_q, CH_NL};
    end
  endtask

  task automatic load_directed();
    push_str("\n");
    push_str("c\t1\tA\t8\tAaCcTtGg\n");
    push_str("c\t1\tG\t4\t.,^A$+2AC-0T\n");
    push_str("c\t1\tN\t3\t.,x*T\t\t\t\t\n");
    push_str("c\t1\tT\t1048576\tTT\n");
    push_str("c\t1\t\t00\t+99999\tA\n");
    for (int b = 0; b < 8; b++) text_q = {text_q, 8'(8'h01 << b)};
    text_q = {text_q, 8'hFF};
    push_str("\n");
  endtask

  initial begin
    int n;
    sb = new();
    sb.clear_line();
    sb.errors = 0; sb.lines_seen = 0; sb.bytes_seen = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_byte = 8'd0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    load_directed();
    while (text_q.size() > 0) send_byte(text_q.pop_front());
    n = 0;
    while (n < 1150) begin
      gen_random_line();
      while (text_q.size() > 0) begin
        send_byte(text_q.pop_front());
        n++;
      end
    end
    in_ch.valid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (4 * (CB + FB + 1) + 10) @(posedge clk);
    $display("Sent %0d text bytes and checked %0d line results against the predictor.",
             sb.bytes_seen, sb.lines_seen);
    if (sb.errors == 0) begin
      $display("pileup_base_frequency_parser_tb: clean");
    end else begin
      $display("pileup_base_frequency_parser_tb: errors");
    end
    $finish;
  end

  int stall_left;
  initial begin
    out_ch.ready = 1'b0;
    stall_left = 0;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left <= gap_len();
    end
  end

  always @(posedge clk) begin
    line_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.freq_a = out_ch.freq_a; got.freq_c = out_ch.freq_c;
      got.freq_t = out_ch.freq_t; got.freq_g = out_ch.freq_g;
      got.count_a = out_ch.count_a; got.count_c = out_ch.count_c;
      got.count_t = out_ch.count_t; got.count_g = out_ch.count_g;
      got.adjusted_depth = out_ch.adjusted_depth; got.zero_depth = out_ch.zero_depth;
      sb.check_result(got);
    end
  end

  initial begin
    #20000000;
    $display("pileup_base_frequency_parser_tb: errors");
    $finish;
  end
endmodule
